FILE: hdl/idmt_overcurrent_trip_macros.svh
// Assertion macros for the overcurrent trip block checker.
// Depends on a clk and an active-low rst_n in the scope of each use.
`ifndef IDMT_OVERCURRENT_TRIP_MACROS_SVH
`define IDMT_OVERCURRENT_TRIP_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define IDMT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that stays armed through reset.
`define IDMT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/idmt_pkg.sv
// Shared widths, codes and reset values for the overcurrent trip block.
// No dependencies; imported by the divider, the top level and the checker.
package idmt_pkg;

  localparam int CUR_W   = 17;
  localparam int PICK_W  = 17;
  localparam int CURVE_W = 16;
  localparam int TIME_W  = 32;
  localparam int STAT_W  = 2;

  // Trip time numerator is curve * pickup, exact
  localparam int NUM_W = CURVE_W + PICK_W;
  localparam int DEN_W = CUR_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 17;
  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CFG_ADDR_W-1:0] REG_PICKUP = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_CURVE  = 1'b1;

  localparam logic [PICK_W-1:0]  PICKUP_RST = 17'd2000;
  localparam logic [CURVE_W-1:0] CURVE_RST  = 16'd675;

  localparam logic [STAT_W-1:0] ST_NORMAL  = 2'd0;
  localparam logic [STAT_W-1:0] ST_TIMING  = 2'd1;
  localparam logic [STAT_W-1:0] ST_TRIPPED = 2'd2;
  localparam logic [STAT_W-1:0] ST_SENSOR  = 2'd3;

  typedef struct packed {
    logic               start;
    logic [CURVE_W-1:0] curve;
    logic [PICK_W-1:0]  pick;
    logic [DEN_W-1:0]   den;
  } div_req_t;

endpackage

FILE: hdl/idmt_div.sv
// Restoring divider: forms curve * pickup, then divides by the excess
// current one quotient bit per cycle. Depends on idmt_pkg.
module idmt_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  idmt_pkg::div_req_t         req,
  output logic                       done,
  output logic [idmt_pkg::TIME_W-1:0] quo
);
  import idmt_pkg::*;

  logic [NUM_W-1:0] work_r;
  logic [DEN_W:0]   rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [NUM_W-1:0] prod;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign prod   = NUM_W'(req.curve) * NUM_W'(req.pick);
  assign rem_sh = {rem_r[DEN_W-1:0], work_r[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign diff   = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Numerator shifts out the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (req.start) begin
      work_r <= prod;
      rem_r  <= '0;
      den_r  <= req.den;
    end else if (busy_r) begin
      work_r <= {work_r[NUM_W-2:0], ge};
      rem_r  <= ge ? diff : rem_sh;
    end
  end

  assign done = done_r;
  // Saturate a 33-bit quotient to 32 bits
  assign quo  = work_r[NUM_W-1] ? {TIME_W{1'b1}} : work_r[TIME_W-1:0];

endmodule

FILE: hdl/idmt_overcurrent_trip.sv
// IDMT overcurrent trip (IEC very inverse, alpha 1), top level; uses idmt_pkg, idmt_div.
// A sample above pickup passes load, compare and the 33-step divider loop before its
// result is registered; every other sample skips the divider.
// Only one sample is taken at a time; in_tready is
// low while a sample is in work. Synchronous active-low reset clears trip latch,
// fault timer and output valid, and loads pickup 2000 mA and curve 675 ms.
module idmt_overcurrent_trip (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [idmt_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [idmt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // Sample stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [16:0] current_ma, [48:17] time_ms, [55:49] zero
  input  logic [idmt_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] sample_valid, [1] reset_pressed
  input  logic [idmt_pkg::IN_TUSER_W-1:0]     in_tuser,
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] trip_time_ms, [32] relay_open, [39:33] zero
  output logic [idmt_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [1:0] status
  output logic [idmt_pkg::STAT_W-1:0]         out_tuser
);
  import idmt_pkg::*;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  // What the finishing step has to report
  localparam logic [1:0] K_BLOCK  = 2'd0;
  localparam logic [1:0] K_SENSOR = 2'd1;
  localparam logic [1:0] K_NORMAL = 2'd2;
  localparam logic [1:0] K_FAULT  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [1:0]         kind_r, kind_nxt;
  logic               trip_r, trip_nxt;
  logic               fault_r, fault_nxt;
  logic [TIME_W-1:0]  start_r, start_nxt;

  logic [PICK_W-1:0]  pickup_r;
  logic [CURVE_W-1:0] curve_r;

  // Captured sample
  logic [CUR_W-1:0]   cur_r;
  logic               valid_r;
  logic               rstp_r;
  logic [TIME_W-1:0]  now_r;

  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [TIME_W-1:0]  out_time_r, out_time_nxt;
  logic               out_open_r, out_open_nxt;

  logic               in_beat;
  logic               unlatch;
  logic               fault_eff;
  logic [TIME_W-1:0]  elapsed;
  div_req_t           div_req;
  logic               div_done;
  logic [TIME_W-1:0]  div_quo;

  assign in_tready = (state_r == S_IDLE);
  assign in_beat   = in_tvalid && in_tready;

  // A reset press only matters while the trip is latched
  assign unlatch   = trip_r && rstp_r;
  assign fault_eff = fault_r && !unlatch;
  // Elapsed fault time wraps modulo 2^32
  assign elapsed   = now_r - start_r;

  idmt_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    trip_nxt       = trip_r;
    fault_nxt      = fault_r;
    start_nxt      = start_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_time_nxt   = out_time_r;
    out_open_nxt   = out_open_r;

    div_req.start = 1'b0;
    div_req.curve = curve_r;
    div_req.pick  = pickup_r;
    div_req.den   = cur_r - pickup_r;

    // Drop a result once the sink takes it
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (unlatch) begin
          trip_nxt  = 1'b0;
          fault_nxt = 1'b0;
        end
        if (trip_r && !rstp_r) begin
          kind_nxt  = K_BLOCK;
          state_nxt = S_FIN;
        end else if (!valid_r) begin
          // Hold the fault timer across a bad reading
          kind_nxt  = K_SENSOR;
          state_nxt = S_FIN;
        end else if (cur_r > pickup_r) begin
          fault_nxt = 1'b1;
          if (!fault_eff) begin
            start_nxt = now_r;
          end
          div_req.start = 1'b1;
          kind_nxt      = K_FAULT;
          state_nxt     = S_DIV;
        end else begin
          fault_nxt = 1'b0;
          kind_nxt  = K_NORMAL;
          state_nxt = S_FIN;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // Wait for the output register to free up
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          case (kind_r)
            K_BLOCK: begin
              out_status_nxt = ST_TRIPPED;
              out_time_nxt   = '0;
              out_open_nxt   = 1'b1;
            end
            K_SENSOR: begin
              out_status_nxt = ST_SENSOR;
              out_time_nxt   = '0;
              out_open_nxt   = 1'b0;
            end
            K_FAULT: begin
              out_time_nxt = div_quo;
              if (elapsed >= div_quo) begin
                trip_nxt       = 1'b1;
                out_status_nxt = ST_TRIPPED;
                out_open_nxt   = 1'b1;
              end else begin
                out_status_nxt = ST_TIMING;
                out_open_nxt   = 1'b0;
              end
            end
            default: begin
              out_status_nxt = ST_NORMAL;
              out_time_nxt   = '0;
              out_open_nxt   = 1'b0;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      trip_r      <= 1'b0;
      fault_r     <= 1'b0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      trip_r      <= trip_nxt;
      fault_r     <= fault_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Settings: the user must write them only while idle; the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pickup_r <= PICKUP_RST;
      curve_r  <= CURVE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PICKUP: pickup_r <= cfg_wdata[PICK_W-1:0];
        REG_CURVE:  curve_r  <= cfg_wdata[CURVE_W-1:0];
        default:    ;
      endcase
    end
  end

  // Payload registers: capture on the input beat, hold otherwise
  always_ff @(posedge clk) begin
    if (in_beat) begin
      cur_r   <= in_tdata[CUR_W-1:0];
      now_r   <= in_tdata[CUR_W+TIME_W-1:CUR_W];
      valid_r <= in_tuser[0];
      rstp_r  <= in_tuser[1];
    end
    kind_r       <= kind_nxt;
    out_status_r <= out_status_nxt;
    out_time_r   <= out_time_nxt;
    out_open_r   <= out_open_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-TIME_W-1){1'b0}}, out_open_r, out_time_r};
  assign out_tuser  = out_status_r;

endmodule

FILE: hdl/idmt_chk.sv
// Port-level checker for the overcurrent trip block, bound to the top level.
// Depends on idmt_pkg and idmt_overcurrent_trip_macros.svh.
`include "idmt_overcurrent_trip_macros.svh"

module idmt_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [idmt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [idmt_pkg::STAT_W-1:0]      out_tuser
);
  import idmt_pkg::*;

  // Relay opens exactly on a tripped status
  `IDMT_ASSERT(a_open_tripped, out_tvalid |-> (out_tdata[TIME_W] == (out_tuser == ST_TRIPPED)), "relay_open disagrees with status")

  // No trip time outside fault timing or a fresh trip
  `IDMT_ASSERT(a_time_zero, (out_tvalid && (out_tuser == ST_NORMAL || out_tuser == ST_SENSOR)) |-> (out_tdata[TIME_W-1:0] == '0), "trip time nonzero on normal or sensor status")

  // One sample at a time: busy right after a beat
  `IDMT_ASSERT(a_busy_after_beat, (in_tvalid && in_tready) |=> !in_tready, "ready stayed high after an input beat")

  // A stalled result holds
  `IDMT_ASSERT(a_out_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)), "stalled result changed")

  // Reset leaves the block empty and ready
  `IDMT_ASSERT_RST(a_reset_empty, !rst_n |=> (!out_tvalid && in_tready), "block not empty after reset")

endmodule

bind idmt_overcurrent_trip idmt_chk u_idmt_chk (.*);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for idmt_overcurrent_trip: stream driver, result monitor, trip predictor.
// Depends on idmt_pkg and the idmt_overcurrent_trip RTL; needs nothing else to run.
module testbench;
  import idmt_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int IDLE_PERCENT = 12;
  localparam int LONG_HOLD    = 400;
  localparam int LIMIT_CYCLES = 400000;
  localparam int CUR_MAX      = (1 << CUR_W) - 1;
  localparam int ITEMS_PER_SETTING = 75;
  localparam int N_SETTINGS   = 8;

  // One current sample as the sender sees it
  typedef struct packed {
    logic [CUR_W-1:0]  current_ma;
    logic              sample_valid;
    logic              reset_pressed;
    logic [TIME_W-1:0] time_ms;
  } sample_t;

  // One relay verdict as the block reports it
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [TIME_W-1:0] trip_ms;
    logic              relay_open;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STAT_W-1:0] out_tuser;

  idmt_overcurrent_trip dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [16:0] current_ma, [48:17] time_ms, [55:49] zero
    .in_tuser   (in_tuser),   // [0] sample_valid, [1] reset_pressed
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [31:0] trip_time_ms, [32] relay_open, [39:33] zero
    .out_tuser  (out_tuser)   // [1:0] status
  );

  always #HALF_PERIOD clk = ~clk;

  // Samples waiting to be offered, and verdicts owed by the block, oldest first
  sample_t  sample_fifo[$];
  verdict_t owed_verdicts[$];

  // Predictor copy of the settings and of the relay state
  logic [PICK_W-1:0]  pickup_q;
  logic [CURVE_W-1:0] curve_q;
  logic               latched_q;
  logic               fault_q;
  logic [TIME_W-1:0]  fault_start_q;

  int samples_queued = 0;
  int samples_taken = 0;
  int results_checked = 0;
  int errors = 0;
  int cycle_count = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  logic in_took = 1'b0;
  logic steady_flow = 1'b0;
  int hold_asks = 0;
  int hold_served = 0;
  int hold_left = 0;
  logic [TIME_W-1:0] clock_ms = '0;

  // Trip time = curve * pickup / (I - pickup), truncated, saturated at 32 bits.
  // Only called with current above pickup, so the divisor is at least one.
  function automatic logic [TIME_W-1:0] idmt_trip_ms(logic [CUR_W-1:0] cur,
                                                     logic [PICK_W-1:0] pick,
                                                     logic [CURVE_W-1:0] curve);
    logic [63:0] num;
    logic [63:0] quo;
    logic [CUR_W-1:0] excess;
    excess = cur - pick;
    num = {48'd0, curve} * {47'd0, pick};
    quo = num / {47'd0, excess};
    if (quo > 64'hFFFF_FFFF) quo = 64'hFFFF_FFFF;
    return quo[TIME_W-1:0];
  endfunction

  // Advance the relay state by one sample and return the verdict it earns
  function automatic verdict_t relay_verdict(sample_t s);
    verdict_t v;
    logic [TIME_W-1:0] trip_ms;
    logic [TIME_W-1:0] elapsed;
    // a reset press releases a latched trip, then the same sample goes on
    if (latched_q && s.reset_pressed) begin
      latched_q = 1'b0;
      fault_q = 1'b0;
    end
    if (latched_q) begin
      v = '{ST_TRIPPED, '0, 1'b1};
    end else if (!s.sample_valid) begin
      // sensor error leaves a running fault timer alone
      v = '{ST_SENSOR, '0, 1'b0};
    end else if (s.current_ma > pickup_q) begin
      if (!fault_q) begin
        fault_q = 1'b1;
        fault_start_q = s.time_ms;
      end
      trip_ms = idmt_trip_ms(s.current_ma, pickup_q, curve_q);
      elapsed = s.time_ms - fault_start_q;
      if (elapsed >= trip_ms) begin
        latched_q = 1'b1;
        v = '{ST_TRIPPED, trip_ms, 1'b1};
      end else begin
        v = '{ST_TIMING, trip_ms, 1'b0};
      end
    end else begin
      fault_q = 1'b0;
      v = '{ST_NORMAL, '0, 1'b0};
    end
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
    $display("MISMATCH @%0t result %0d: %s want %0d got %0d",
             $realtime, results_checked, what, want, got);
    errors++;
  endtask

  task automatic queue_sample(int unsigned cur, bit valid, bit press, logic [TIME_W-1:0] t);
    sample_t s;
    s.current_ma = cur[CUR_W-1:0];
    s.sample_valid = valid;
    s.reset_pressed = press;
    s.time_ms = t;
    sample_fifo.push_back(s);
    samples_queued++;
  endtask

  // Hold the sender until every queued sample is taken and every verdict is back
  task automatic wait_idle();
    while (samples_taken != samples_queued || owed_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write one setting while the block is idle; the predictor follows at once
  task automatic write_setting(logic [CFG_ADDR_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PICKUP) pickup_q = val[PICK_W-1:0];
    else curve_q = val[CURVE_W-1:0];
  endtask

  // Random samples grouped in runs: mostly sustained faults with a moving
  // level and clock, some quiet runs, and a share of pure noise.
  task automatic queue_random_runs(int count);
    int made;
    int kind;
    int len;
    int r;
    int unsigned span;
    int unsigned cur;
    int unsigned step;
    bit valid;
    bit press;
    made = 0;
    while (made < count) begin
      kind = $urandom_range(99, 0);
      len = $urandom_range(12, 2);
      for (int k = 0; k < len && made < count; k++) begin
        r = $urandom_range(99, 0);
        if (r < 70) step = $urandom_range(300, 0);
        else if (r < 92) step = $urandom_range(20000, 0);
        else if (r < 98) step = $urandom;
        else step = 0;
        clock_ms = clock_ms + step;
        valid = ($urandom_range(99, 0) >= 6);
        // press more often at the start of a run so latched trips get released
        press = ($urandom_range(99, 0) < ((k == 0) ? 30 : 8));
        span = CUR_MAX - pickup_q;
        if (kind < 60 && span > 0) begin
          if ($urandom_range(1, 0)) cur = pickup_q + 1 + $urandom_range(span - 1, 0);
          else cur = pickup_q + 1 + $urandom_range((span > 64) ? 63 : span - 1, 0);
        end else if (kind < 85) begin
          cur = ($urandom_range(99, 0) < 20) ? pickup_q : $urandom_range(pickup_q, 0);
        end else begin
          cur = $urandom_range(CUR_MAX, 0);
          valid = $urandom_range(1, 0);
          press = $urandom_range(1, 0);
          clock_ms = $urandom;
        end
        queue_sample(cur, valid, press, clock_ms);
        made++;
      end
    end
  endtask

  // Sender: offer the next sample on the falling edge; hold a beat until taken
  always @(negedge clk) begin : drive_samples
    sample_t beat;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_took) begin
      // hold data and valid steady until the handshake
    end else if (sample_fifo.size() != 0 &&
                 (steady_flow || $urandom_range(99, 0) >= IDLE_PERCENT)) begin
      beat = sample_fifo.pop_front();
      in_tvalid <= 1'b1;
      in_tdata <= {7'd0, beat.time_ms, beat.current_ma};
      in_tuser <= {beat.reset_pressed, beat.sample_valid};
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Receiver: random back-pressure, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served < hold_asks) begin
      hold_served <= hold_served + 1;
      hold_left <= LONG_HOLD;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady_flow || ($urandom_range(99, 0) >= IDLE_PERCENT);
    end
  end

  // Monitor: sample both handshakes on the rising edge. Check the result
  // beat against the oldest owed verdict, then predict for the input beat.
  always @(posedge clk) begin : watch_beats
    verdict_t got;
    verdict_t want;
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        got.status = out_tuser;
        got.trip_ms = out_tdata[31:0];
        got.relay_open = out_tdata[32];
        if (owed_verdicts.size() == 0) begin
          report_mismatch("result beat with nothing outstanding, status", 0, got.status);
        end else begin
          want = owed_verdicts.pop_front();
          if (got.status != want.status)
            report_mismatch("status", want.status, got.status);
          if (got.trip_ms != want.trip_ms)
            report_mismatch("trip_time_ms", want.trip_ms, got.trip_ms);
          if (got.relay_open != want.relay_open)
            report_mismatch("relay_open", want.relay_open, got.relay_open);
        end
        status_seen[got.status]++;
        results_checked++;
      end
      if (in_tvalid && in_tready) begin
        owed_verdicts.push_back(relay_verdict({in_tdata[CUR_W-1:0], in_tuser[0], in_tuser[1],
                                               in_tdata[CUR_W+TIME_W-1:CUR_W]}));
        samples_taken++;
      end
    end
  end

  // Watchdog: end the run if the block stops making progress
  initial begin
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles, %0d verdicts still owed",
             cycle_count, owed_verdicts.size());
    $display("idmt_overcurrent_trip test failed");
    $finish;
  end

  initial begin
    int unsigned pick_set[N_SETTINGS];
    int unsigned curve_set[N_SETTINGS];
    pick_set = '{2000, 1, 100000, 5000, 20000, 0, 60000, 1};
    curve_set = '{675, 0, 65535, 300, 1000, 675, 40000, 65535};
    pickup_q = PICKUP_RST;
    curve_q = CURVE_RST;
    latched_q = 1'b0;
    fault_q = 1'b0;
    fault_start_q = '0;

    // Reset once
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset settings: pickup 2000 mA, curve 675 ms
    queue_sample(0, 1, 0, 32'd0);              // no current
    queue_sample(2000, 1, 0, 32'd50);          // exactly at pickup stays normal
    queue_sample(50000, 0, 0, 32'd60);         // sensor error
    queue_sample(2001, 1, 0, 32'd100);         // one mA over pickup: fault starts, long time
    queue_sample(4000, 0, 0, 32'd200);         // sensor error mid-fault keeps the timer
    queue_sample(4000, 1, 1, 32'd300);         // press while not tripped changes nothing
    queue_sample(4000, 1, 0, 32'd775);         // elapsed reaches trip time exactly
    queue_sample(0, 1, 0, 32'd800);            // latched
    queue_sample(0, 0, 0, 32'd900);            // latch outranks a sensor error
    queue_sample(0, 1, 1, 32'd1000);           // press releases, sample then normal
    queue_sample(CUR_MAX, 1, 1, 32'hFFFF_FF00);// full-scale current, fault near wrap
    queue_sample(CUR_MAX, 1, 0, 32'h0000_0010);// elapsed across the wrap trips
    queue_sample(0, 0, 1, 32'h0000_0020);      // press releases, then sensor error
    queue_sample(100000, 1, 0, 32'hFFFF_FFFF); // top of range starts a new fault
    queue_sample(0, 1, 0, 32'h0000_0005);      // drop below pickup clears the fault
    wait_idle();

    // Zero curve time: first faulted sample trips, and again right after a press
    write_setting(REG_CURVE, 0);
    queue_sample(2500, 1, 0, 32'd2000);
    queue_sample(2500, 1, 1, 32'd2100);
    wait_idle();

    // Top settings: trip time saturates, elapsed of 2^32-1 still reaches it
    write_setting(REG_PICKUP, 100000);
    write_setting(REG_CURVE, 65535);
    queue_sample(100001, 1, 1, 32'd50);
    queue_sample(CUR_MAX, 1, 0, 32'd10000);
    queue_sample(100001, 1, 0, 32'd49);
    wait_idle();

    // Zero pickup: any current is a fault, and the trip time is zero
    write_setting(REG_PICKUP, 0);
    write_setting(REG_CURVE, 675);
    queue_sample(0, 1, 1, 32'd7);
    queue_sample(1, 1, 0, 32'd8);
    queue_sample(0, 1, 1, 32'd9);
    wait_idle();

    // Random part, one batch per setting, with an idle pause between settings
    for (int p = 0; p < N_SETTINGS; p++) begin
      write_setting(REG_PICKUP, pick_set[p]);
      write_setting(REG_CURVE, curve_set[p]);
      steady_flow = (p == 3);
      clock_ms = $urandom;
      queue_random_runs(ITEMS_PER_SETTING);
      // stall the receiver while the sender keeps offering, to back the block up
      if (p == 4) hold_asks = hold_asks + 1;
      wait_idle();
    end
    steady_flow = 1'b0;

    wait_idle();
    repeat (50) @(posedge clk);
    $display("checked %0d verdicts for %0d samples over %0d settings", results_checked,
             samples_taken, N_SETTINGS + 4);
    $display("seen: %0d normal, %0d timing, %0d tripped, %0d sensor error",
             status_seen[ST_NORMAL], status_seen[ST_TIMING], status_seen[ST_TRIPPED],
             status_seen[ST_SENSOR]);
    if (errors == 0 && owed_verdicts.size() == 0) begin
      $display("idmt_overcurrent_trip test passed");
    end else begin
      $display("idmt_overcurrent_trip test failed");
    end
    $finish;
  end

endmodule
